### rtl/core/single_wire_humidity_sensor_reader_defines.svh
// Assertion macros for the single-wire humidity sensor reader checker
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SWHSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swhsr check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SWHSR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swhsr check failed");

`endif

### rtl/core/swhsr_pkg.sv
// Package: types, codes and constants of the single-wire humidity sensor reader
package swhsr_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int TS_W          = 32;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_BYTES     = 5;
  localparam int DATA_BITS     = 40;
  localparam int RX_W          = NUM_BYTES * 8;
  localparam int BIT_IDX_W     = 6;
  localparam int ERR_W         = 3;

  localparam logic [CFG_W-1:0] REQUEST_LOW_RST  = 8'd18;
  localparam logic [CFG_W-1:0] READ_TIMEOUT_RST = 8'd10;
  localparam logic [CFG_W-1:0] RESPONSE_MIN_RST = 8'd80;
  localparam logic [CFG_W-1:0] ONE_THRESH_RST   = 8'd49;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RISE  = 2'd1,
    OP_FALL  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_READY    = 3'd0,
    PH_REQUEST  = 3'd1,
    PH_PULLDOWN = 3'd2,
    PH_PULSE    = 3'd3,
    PH_BITS     = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUEST_LOW  = 3'd0,
    CFG_READ_TIMEOUT = 3'd1,
    CFG_RESPONSE_MIN = 3'd2,
    CFG_ONE_THRESH   = 3'd3
  } cfg_idx_e;

  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NOT_READ    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_RESPONSE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TIMEOUT     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHECKSUM    = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] request_low_ms;
    logic [CFG_W-1:0] read_timeout_ms;
    logic [CFG_W-1:0] response_min_us;
    logic [CFG_W-1:0] one_threshold_us;
  } cfg_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [ERR_W-1:0] error_code;
    logic             data_valid;
    logic [31:0]      data_word;
    logic [7:0]       checksum_byte;
  } result_t;

endpackage

### rtl/core/swhsr_if.sv
// Request and result channel interfaces of the humidity sensor reader
interface swhsr_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] timestamp_us;

  modport source (output valid, operation, timestamp_us, input ready);
  modport sink   (input valid, operation, timestamp_us, output ready);
endinterface

interface swhsr_res_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [2:0]  error_code;
  logic        data_valid;
  logic [31:0] data_word;
  logic [7:0]  checksum_byte;

  modport source (output valid, drive_low, busy_res, done_res, error_code, data_valid,
                  data_word, checksum_byte, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, error_code, data_valid,
                  data_word, checksum_byte, output ready);
endinterface

### rtl/core/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader
// Usage:
//   evt_i carries one request per event: start, rising edge, falling edge or
//   1 ms tick, each with a microsecond timestamp. res_o returns exactly one
//   result per request: line drive, busy, done, last error, sticky valid flag
//   and the received bytes, all showing the state after that event.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the four timing registers; write only
//   while no request is in flight.
// Timing:
//   A request is held in the input register; its result is computed from it
//   and registered in the output register, from which res_o offers it. One
//   request per cycle is sustained while res_o.ready stays high.
// Reset:
//   The timing registers return to their defaults, the sequencer goes idle with error
//   "not read" and the valid flag cleared; no result is pending.
// Stall:
//   A held result keeps its value; the input register still fills behind it,
//   then evt_i.ready drops until res_o.ready returns.
module single_wire_humidity_sensor_reader #(
  parameter int TIME_BITS = swhsr_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  swhsr_evt_if.sink                       evt_i,
  swhsr_res_if.source                     res_o,
  input  logic                            cfg_we_i,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swhsr_pkg::CFG_W-1:0]     cfg_data_i
);
  import swhsr_pkg::*;

  cfg_t          cfg;
  result_t       res_comb;
  result_t       res_q;
  logic          in_v_q;
  logic [1:0]    in_op_q;
  logic [TS_W-1:0] in_ts_q;
  logic          out_v_q;
  logic          out_rdy;
  logic          in_rdy;
  logic          step;

  assign out_rdy     = !out_v_q || res_o.ready;
  assign in_rdy      = !in_v_q || out_rdy;
  assign step        = in_v_q && out_rdy;
  assign evt_i.ready = in_rdy;

  swhsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swhsr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .op_i   (in_op_q),
    .ts_i   (in_ts_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_rdy) in_v_q <= evt_i.valid;
      if (out_rdy) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && evt_i.valid) begin
      in_op_q <= evt_i.operation;
      in_ts_q <= evt_i.timestamp_us;
    end
    if (step) res_q <= res_comb;
  end

  assign res_o.valid         = out_v_q;
  assign res_o.drive_low     = res_q.drive_low;
  assign res_o.busy_res      = res_q.busy_res;
  assign res_o.done_res      = res_q.done_res;
  assign res_o.error_code    = res_q.error_code;
  assign res_o.data_valid    = res_q.data_valid;
  assign res_o.data_word     = res_q.data_word;
  assign res_o.checksum_byte = res_q.checksum_byte;

endmodule

### rtl/core/swhsr_cfg.sv
// Configuration register file of the humidity sensor reader
module swhsr_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swhsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swhsr_pkg::CFG_W-1:0]     cfg_data_i,
  output swhsr_pkg::cfg_t                 cfg_o
);
  import swhsr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REQUEST_LOW:  cfg_d.request_low_ms   = cfg_data_i;
        CFG_READ_TIMEOUT: cfg_d.read_timeout_ms  = cfg_data_i;
        CFG_RESPONSE_MIN: cfg_d.response_min_us  = cfg_data_i;
        CFG_ONE_THRESH:   cfg_d.one_threshold_us = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_low_ms   <= REQUEST_LOW_RST;
      cfg_q.read_timeout_ms  <= READ_TIMEOUT_RST;
      cfg_q.response_min_us  <= RESPONSE_MIN_RST;
      cfg_q.one_threshold_us <= ONE_THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/swhsr_core.sv
// Read sequencer: phase, timer, bit decode and checksum, one request per step
module swhsr_core #(
  parameter int TIME_BITS = swhsr_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [1:0]                 op_i,
  input  logic [swhsr_pkg::TS_W-1:0] ts_i,
  input  swhsr_pkg::cfg_t            cfg_i,
  output swhsr_pkg::result_t         res_o
);
  import swhsr_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [BIT_IDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [TIME_BITS-1:0]   last_edge_q, last_edge_d;
  logic [RX_W-1:0]        rx_q, rx_d;
  logic [CFG_W-1:0]       timer_q, timer_d;
  logic                   timer_on_q, timer_on_d;
  logic [ERR_W-1:0]       err_q, err_d;
  logic                   valid_q, valid_d;
  logic                   done;

  logic [TIME_BITS-1:0]   now;
  logic [TIME_BITS-1:0]   pulse;
  logic                   bit_val;
  logic                   edges_on;
  logic [2:0]             byte_no;
  logic [BIT_IDX_W-1:0]   bit_inc;
  logic [7:0]             byte_sel;
  logic [7:0]             sum;

  assign now      = ts_i[TIME_BITS-1:0];
  assign pulse    = now - last_edge_q;
  assign bit_val  = pulse > TIME_BITS'(cfg_i.one_threshold_us);
  assign edges_on = (phase_q == PH_PULLDOWN) || (phase_q == PH_PULSE) ||
                    (phase_q == PH_BITS);
  assign byte_no  = bit_idx_q[5:3];
  assign bit_inc  = bit_idx_q + BIT_IDX_W'(1);

  always_comb begin
    phase_d     = phase_q;
    bit_idx_d   = bit_idx_q;
    last_edge_d = last_edge_q;
    rx_d        = rx_q;
    timer_d     = timer_q;
    timer_on_d  = timer_on_q;
    err_d       = err_q;
    valid_d     = valid_q;
    done        = 1'b0;
    byte_sel    = 8'd0;
    sum         = 8'd0;

    unique case (op_e'(op_i))
      OP_START: begin
        rx_d       = '0;
        bit_idx_d  = '0;
        phase_d    = PH_REQUEST;
        timer_d    = cfg_i.request_low_ms;
        timer_on_d = 1'b1;
      end
      OP_RISE: begin
        if (edges_on) last_edge_d = now;
      end
      OP_FALL: begin
        if (edges_on) begin
          last_edge_d = now;
          if (phase_q == PH_PULLDOWN) begin
            phase_d = PH_PULSE;
          end else if (phase_q == PH_PULSE) begin
            if (pulse < TIME_BITS'(cfg_i.response_min_us)) begin
              err_d      = ERR_NO_RESPONSE;
              phase_d    = PH_READY;
              timer_on_d = 1'b0;
              timer_d    = '0;
              done       = 1'b1;
            end else begin
              phase_d   = PH_BITS;
              bit_idx_d = '0;
            end
          end else begin
            for (int k = 0; k < NUM_BYTES; k++) begin
              if (byte_no == 3'(k)) begin
                byte_sel = rx_q[(NUM_BYTES-1-k)*8 +: 8];
                rx_d[(NUM_BYTES-1-k)*8 +: 8] = {byte_sel[6:0], bit_val};
              end
            end
            bit_idx_d = bit_inc;
            if (bit_inc >= BIT_IDX_W'(DATA_BITS)) begin
              sum = rx_d[39:32] + rx_d[31:24] + rx_d[23:16] + rx_d[15:8];
              if (sum == rx_d[7:0]) begin
                valid_d = 1'b1;
                err_d   = ERR_NONE;
              end else begin
                err_d   = ERR_CHECKSUM;
              end
              phase_d    = PH_READY;
              timer_on_d = 1'b0;
              timer_d    = '0;
              done       = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (timer_on_q && (phase_q != PH_READY)) begin
          if (timer_q <= CFG_W'(1)) begin
            timer_on_d = 1'b0;
            timer_d    = '0;
            if (phase_q == PH_REQUEST) begin
              phase_d     = PH_PULLDOWN;
              last_edge_d = now;
              timer_d     = cfg_i.read_timeout_ms;
              timer_on_d  = 1'b1;
            end else begin
              err_d   = ERR_TIMEOUT;
              phase_d = PH_READY;
              done    = 1'b1;
            end
          end else begin
            timer_d = timer_q - CFG_W'(1);
          end
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_READY;
      bit_idx_q   <= '0;
      last_edge_q <= '0;
      rx_q        <= '0;
      timer_q     <= '0;
      timer_on_q  <= 1'b0;
      err_q       <= ERR_NOT_READ;
      valid_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_idx_q   <= bit_idx_d;
      last_edge_q <= last_edge_d;
      rx_q        <= rx_d;
      timer_q     <= timer_d;
      timer_on_q  <= timer_on_d;
      err_q       <= err_d;
      valid_q     <= valid_d;
    end
  end

  always_comb begin
    res_o.drive_low     = (phase_d == PH_REQUEST);
    res_o.busy_res      = (phase_d != PH_READY);
    res_o.done_res      = done;
    res_o.error_code    = err_d;
    res_o.data_valid    = valid_d;
    res_o.data_word     = rx_d[RX_W-1:8];
    res_o.checksum_byte = rx_d[7:0];
  end

endmodule

### rtl/core/swhsr_checker.sv
// Port-level checker for the humidity sensor reader, bound to the top level
`include "single_wire_humidity_sensor_reader_defines.svh"

module swhsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        drive_low,
  input logic        busy_res,
  input logic        done_res,
  input logic [2:0]  error_code,
  input logic        data_valid,
  input logic [31:0] data_word
);
  import swhsr_pkg::*;

  `SWHSR_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res)
  `SWHSR_ASSERT_IMP(a_drive_busy, out_valid && drive_low, busy_res)
  `SWHSR_ASSERT_IMP(a_ok_valid, out_valid && done_res && (error_code == ERR_NONE), data_valid)
  `SWHSR_ASSERT_IMP(a_bp_source, !in_ready, out_valid && !out_ready)
  `SWHSR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(data_word))

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (evt_i.ready),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .drive_low  (res_o.drive_low),
  .busy_res   (res_o.busy_res),
  .done_res   (res_o.done_res),
  .error_code (res_o.error_code),
  .data_valid (res_o.data_valid),
  .data_word  (res_o.data_word)
);
